### design/etfp_pkg.sv
// Package for the escape-time fractal pixel block.
// Holds shared types, register indexes and constants; no dependencies.
package etfp_pkg;

  localparam int unsigned ScreenWidthDef  = 1920;
  localparam int unsigned ScreenHeightDef = 1080;

  localparam logic signed [31:0] CenterRealRst = -32'sd134217728;
  localparam logic signed [31:0] CenterImagRst = 32'sd0;
  localparam logic [30:0]        PixelStepRst  = 31'd559240;
  localparam logic [15:0]        IterLimitRst  = 16'd600;

  // 2.0 in Q.28 and 4.0 in Q.56
  localparam logic signed [33:0] TwoQ28  = 34'sd536870912;
  localparam logic signed [62:0] FourQ56 = 63'sd288230376151711744;
  localparam logic [31:0]        OneQ31  = 32'h8000_0000;

  localparam logic [31:0] RedK   = 32'd2295;
  localparam logic [31:0] GreenK = 32'd3825;
  localparam logic [31:0] BlueK  = 32'd4335;

  localparam logic [5:0] DivSteps  = 6'd47;
  localparam logic [3:0] PolySteps = 4'd10;

  typedef enum logic [1:0] {
    CFG_CENTER_REAL = 2'd0,
    CFG_CENTER_IMAG = 2'd1,
    CFG_PIXEL_STEP  = 2'd2,
    CFG_ITER_LIMIT  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] center_real;
    logic signed [31:0] center_imag;
    logic [30:0]        pixel_step;
    logic [15:0]        iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
  } point_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctrl_t;

  typedef enum logic {
    F_IDLE = 1'b0,
    F_PUSH = 1'b1
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE = 3'd0,
    B_MUL  = 3'd1,
    B_UPD  = 3'd2,
    B_DIV  = 3'd3,
    B_POLY = 3'd4,
    B_OUT  = 3'd5
  } back_state_e;

endpackage

### design/escape_time_fractal_pixel.sv
// Escape-time fractal pixel, top level: configuration registers, front end,
// point queue and back end. Depends on etfp_pkg, etfp_front, etfp_queue, etfp_back.
//
// Usage: raise start_i with pixel_col_i/pixel_row_i; the item is taken at a
// clock edge where busy_o is low. The front end multiplies at that edge, then
// adds and saturates in the next cycle and hands the point to a two-entry
// queue; busy_o stays high while the front end waits on a full queue.
// The back end takes one point at a time: each recurrence step is a multiply
// state with the box and limit tests, then an |z|^2 escape test and update;
// then come bit-serial division for t, the shared colour multiplier and an
// output state. An |z|^2 escape leaves from the update state, the others from
// the multiply state; a zero limit skips division and colour.
// The back end's run per point sets the throughput.
// Each result shows for one cycle with done_o high; the receiver cannot stall.
// Configuration: cfg_we_i with cfg_idx_i and cfg_wdata_i, only while idle.
// Reset clears the queue and both state machines and loads the default view.
module escape_time_fractal_pixel import etfp_pkg::*; #(
  parameter int unsigned ScreenWidth  = ScreenWidthDef,
  parameter int unsigned ScreenHeight = ScreenHeightDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [10:0]        pixel_col_i,
  input  logic [10:0]        pixel_row_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [31:0] c_real_o,
  output logic signed [31:0] c_imag_o,
  output logic [15:0]        iter_count_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);

  cfg_t    cfg_q;
  point_t  front_pt, back_pt;
  q_ctrl_t q_ctrl;
  logic    push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_real     <= CenterRealRst;
      cfg_q.center_imag     <= CenterImagRst;
      cfg_q.pixel_step      <= PixelStepRst;
      cfg_q.iteration_limit <= IterLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_REAL: cfg_q.center_real     <= cfg_wdata_i;
        CFG_CENTER_IMAG: cfg_q.center_imag     <= cfg_wdata_i;
        CFG_PIXEL_STEP:  cfg_q.pixel_step      <= cfg_wdata_i[30:0];
        CFG_ITER_LIMIT:  cfg_q.iteration_limit <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  etfp_front #(
    .ScreenWidth (ScreenWidth),
    .ScreenHeight(ScreenHeight)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .pixel_col_i(pixel_col_i),
    .pixel_row_i(pixel_row_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_ctrl.full),
    .busy_o     (busy_o),
    .push_o     (push),
    .point_o    (front_pt)
  );

  etfp_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .data_i(front_pt),
    .data_o(back_pt),
    .ctrl_o(q_ctrl)
  );

  etfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_ctrl.empty),
    .point_i     (back_pt),
    .pop_o       (pop),
    .done_o      (done_o),
    .c_real_o    (c_real_o),
    .c_imag_o    (c_imag_o),
    .iter_count_o(iter_count_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule

### design/etfp_front.sv
// Front end: accepts a pixel and maps it to a saturated point of the plane.
// Depends on etfp_pkg; feeds etfp_queue.
module etfp_front import etfp_pkg::*; #(
  parameter int unsigned ScreenWidth  = ScreenWidthDef,
  parameter int unsigned ScreenHeight = ScreenHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [10:0] pixel_col_i,
  input  logic [10:0] pixel_row_i,
  input  cfg_t        cfg_i,
  input  logic        q_full_i,
  output logic        busy_o,
  output logic        push_o,
  output point_t      point_o
);

  front_state_e state_q, state_d;
  logic signed [45:0] prod_x_q, prod_x_d, prod_y_q, prod_y_d;
  logic signed [13:0] dx, dy;
  logic signed [45:0] step_s;
  logic signed [45:0] half_x, half_y;
  logic signed [46:0] sum_x, sum_y;

  assign step_s   = 46'($signed({1'b0, cfg_i.pixel_step}));
  assign dx       = 14'({pixel_col_i, 1'b0}) - 14'(ScreenWidth);
  assign dy       = 14'({pixel_row_i, 1'b0}) - 14'(ScreenHeight);
  assign prod_x_d = 46'(dx) * step_s;
  assign prod_y_d = 46'(dy) * step_s;

  // halve toward zero
  assign half_x = (prod_x_q + $signed({45'd0, prod_x_q[45]})) >>> 1;
  assign half_y = (prod_y_q + $signed({45'd0, prod_y_q[45]})) >>> 1;
  assign sum_x  = 47'(cfg_i.center_real) + 47'(half_x);
  assign sum_y  = 47'(cfg_i.center_imag) - 47'(half_y);

  function automatic logic signed [31:0] sat32(input logic signed [46:0] v);
    if (v > 47'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -47'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  assign point_o.c_real = sat32(sum_x);
  assign point_o.c_imag = sat32(sum_y);
  assign busy_o         = (state_q == F_PUSH);

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        // hold until the queue has room
        if (!q_full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start_i) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
  end

endmodule

### design/etfp_queue.sv
// Two-entry queue of mapped points between front and back end.
// Depends on etfp_pkg.
module etfp_queue import etfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  logic    pop_i,
  input  point_t  data_i,
  output point_t  data_o,
  output q_ctrl_t ctrl_o
);

  point_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign ctrl_o.full  = (cnt_q == 2'd2);
  assign ctrl_o.empty = (cnt_q == 2'd0);
  assign ctrl_o.push  = push_i;
  assign ctrl_o.pop   = pop_i;
  assign data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/etfp_back.sv
// Back end: runs the escape-time recurrence, divides for t and evaluates the
// colour polynomials on one shared multiplier. Depends on etfp_pkg.
module etfp_back import etfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               q_empty_i,
  input  point_t             point_i,
  output logic               pop_o,
  output logic               done_o,
  output logic signed [31:0] c_real_o,
  output logic signed [31:0] c_imag_o,
  output logic [15:0]        iter_count_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);

  back_state_e state_q, state_d;

  logic signed [31:0] cr_q, ci_q;
  logic signed [33:0] zr_q, zi_q;
  logic signed [61:0] rr_q, ii_q, ri_q;
  logic [15:0]        n_q;
  logic [46:0]        num_q;
  logic [15:0]        rem_q;
  logic [5:0]         div_cnt_q;
  logic [3:0]         step_q;
  logic [31:0]        t_q, u_q, t2_q, t3_q, u2_q, u3_q, pa_q, pb_q, pc_q;
  logic [7:0]         red_q, green_q, blue_q;

  logic               out_of_box;
  logic               at_limit;
  logic signed [62:0] mag_sq, diff_sq, twice_ri;
  logic [16:0]        trial;
  logic               trial_ge;
  logic [31:0]        op_a, op_b;
  logic [63:0]        prod;
  logic [32:0]        prod31;
  logic [31:0]        prod32;
  logic [7:0]         clip31;

  assign out_of_box = (zr_q > TwoQ28) || (zr_q < -TwoQ28) ||
                      (zi_q > TwoQ28) || (zi_q < -TwoQ28);
  assign at_limit   = (n_q == cfg_i.iteration_limit);
  assign mag_sq     = 63'(rr_q) + 63'(ii_q);
  assign diff_sq    = 63'(rr_q) - 63'(ii_q);
  assign twice_ri   = {ri_q, 1'b0};

  assign trial    = {rem_q, num_q[46]};
  assign trial_ge = (trial >= {1'b0, cfg_i.iteration_limit});

  always_comb begin
    op_a = t_q;
    op_b = t_q;
    case (step_q)
      4'd0: begin op_a = t_q;  op_b = t_q;  end
      4'd1: begin op_a = t2_q; op_b = t_q;  end
      4'd2: begin op_a = u_q;  op_b = u_q;  end
      4'd3: begin op_a = u2_q; op_b = u_q;  end
      4'd4: begin op_a = u_q;  op_b = t3_q; end
      4'd5: begin op_a = u2_q; op_b = t2_q; end
      4'd6: begin op_a = u3_q; op_b = t_q;  end
      4'd7: begin op_a = RedK;   op_b = pa_q; end
      4'd8: begin op_a = GreenK; op_b = pb_q; end
      4'd9: begin op_a = BlueK;  op_b = pc_q; end
      default: begin op_a = t_q; op_b = t_q; end
    endcase
  end

  assign prod   = op_a * op_b;
  assign prod31 = prod[63:31];
  assign prod32 = prod[63:32];
  assign clip31 = (prod31 > 33'd255) ? 8'd255 : prod31[7:0];

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        if (at_limit || out_of_box) begin
          state_d = (cfg_i.iteration_limit == 16'd0) ? B_OUT : B_DIV;
        end else begin
          state_d = B_UPD;
        end
      end
      B_UPD: begin
        state_d = (mag_sq > FourQ56) ? B_DIV : B_MUL;
      end
      B_DIV: begin
        if (div_cnt_q == DivSteps - 6'd1) begin
          state_d = B_POLY;
        end
      end
      B_POLY: begin
        if (step_q == PolySteps - 4'd1) begin
          state_d = B_OUT;
        end
      end
      B_OUT:   state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        cr_q      <= point_i.c_real;
        ci_q      <= point_i.c_imag;
        zr_q      <= '0;
        zi_q      <= '0;
        n_q       <= '0;
        div_cnt_q <= '0;
        step_q    <= '0;
        red_q     <= '0;
        green_q   <= '0;
        blue_q    <= '0;
      end
      B_MUL: begin
        rr_q  <= 62'($signed(zr_q[30:0]) * $signed(zr_q[30:0]));
        ii_q  <= 62'($signed(zi_q[30:0]) * $signed(zi_q[30:0]));
        ri_q  <= 62'($signed(zr_q[30:0]) * $signed(zi_q[30:0]));
        num_q <= {n_q, 31'd0};
        rem_q <= '0;
      end
      B_UPD: begin
        if (mag_sq <= FourQ56) begin
          zr_q <= 34'(diff_sq >>> 28) + 34'(cr_q);
          zi_q <= 34'(twice_ri >>> 28) + 34'(ci_q);
          n_q  <= n_q + 16'd1;
        end else begin
          num_q <= {n_q, 31'd0};
          rem_q <= '0;
        end
      end
      B_DIV: begin
        // one quotient bit per cycle
        rem_q     <= trial_ge ? 16'(trial - {1'b0, cfg_i.iteration_limit}) : trial[15:0];
        num_q     <= {num_q[45:0], trial_ge};
        div_cnt_q <= div_cnt_q + 6'd1;
        if (div_cnt_q == DivSteps - 6'd1) begin
          t_q <= {num_q[30:0], trial_ge};
          u_q <= OneQ31 - {num_q[30:0], trial_ge};
        end
      end
      B_POLY: begin
        step_q <= step_q + 4'd1;
        case (step_q)
          4'd0: t2_q <= prod31[31:0];
          4'd1: t3_q <= prod31[31:0];
          4'd2: u2_q <= prod31[31:0];
          4'd3: u3_q <= prod31[31:0];
          4'd4: pa_q <= prod31[31:0];
          4'd5: pb_q <= prod31[31:0];
          4'd6: pc_q <= prod31[31:0];
          4'd7: red_q   <= clip31;
          4'd8: green_q <= clip31;
          4'd9: blue_q  <= (prod32 > 32'd255) ? 8'd255 : prod32[7:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign done_o       = (state_q == B_OUT);
  assign c_real_o     = cr_q;
  assign c_imag_o     = ci_q;
  assign iter_count_o = n_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;

`ifndef ASSERT_OFF
  a_out_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_OUT) |=> (state_q == B_IDLE))
    else $error("result strobe longer than one cycle");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_MUL) |-> (n_q <= cfg_i.iteration_limit))
    else $error("iteration count passed the limit");
  a_square_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_UPD) |-> ($past(zr_q) <= TwoQ28 && $past(zr_q) >= -TwoQ28))
    else $error("squared a value outside the escape box");
`endif

endmodule

### tb/sv/tb_escape_time_fractal_pixel.sv
`timescale 1ns / 100ps
// Self-checking testbench for escape_time_fractal_pixel: directed table, then random pixels
// under changing views, each result checked against a built-in pixel predictor.
// Depends on etfp_pkg and the escape_time_fractal_pixel RTL.
module tb_escape_time_fractal_pixel;
  import etfp_pkg::*;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic [15:0]        iter_count;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pixel_t;

  typedef struct {
    bit          load_view;
    int          view_real;
    int          view_imag;
    int unsigned view_step;
    int unsigned view_limit;
    int unsigned col;
    int unsigned row;
    bit          has_known;
    pixel_t      known;
  } pixel_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [10:0]        pixel_col_i;
  logic [10:0]        pixel_row_i;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [31:0]        cfg_wdata_i;
  logic               done_o;
  logic signed [31:0] c_real_o;
  logic signed [31:0] c_imag_o;
  logic [15:0]        iter_count_o;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;

  // view as the block holds it
  longint view_real_q;
  longint view_imag_q;
  longint view_step_q;
  longint view_limit_q;

  pixel_t pending_pixels[$];
  int     error_count;
  int     sender_idle_pct;

  escape_time_fractal_pixel dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint clamp_s32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned qmul31(longint unsigned a, longint unsigned b);
    return (a * b) >> 31;
  endfunction

  function automatic pixel_t predict_pixel(int unsigned col, int unsigned row);
    longint           off_re, off_im, cr, ci, zr, zi, rr, ii, nr;
    longint unsigned  n, t, u, t2, t3, u2, u3, r, g, b;
    pixel_t           p;
    off_re = (longint'(col) * 2 - 1920) * view_step_q / 2;
    off_im = (longint'(row) * 2 - 1080) * view_step_q / 2;
    cr = clamp_s32(view_real_q + off_re);
    ci = clamp_s32(view_imag_q - off_im);
    zr = 0;
    zi = 0;
    n = 0;
    r = 0;
    g = 0;
    b = 0;
    while (n < longint'(view_limit_q)) begin
      // escape on a large part without squaring
      if (zr > 64'sd536870912 || zr < -64'sd536870912 ||
          zi > 64'sd536870912 || zi < -64'sd536870912) break;
      rr = zr * zr;
      ii = zi * zi;
      if (rr + ii > 64'sd288230376151711744) break;
      nr = ((rr - ii) >>> 28) + cr;
      zi = ((2 * zr * zi) >>> 28) + ci;
      zr = nr;
      n++;
    end
    if (view_limit_q != 0) begin
      t  = (n << 31) / longint'(view_limit_q);
      u  = (64'd1 << 31) - t;
      t2 = qmul31(t, t);
      t3 = qmul31(t2, t);
      u2 = qmul31(u, u);
      u3 = qmul31(u2, u);
      r  = (64'd2295 * qmul31(u, t3)) >> 31;
      g  = (64'd3825 * qmul31(u2, t2)) >> 31;
      b  = (64'd4335 * qmul31(u3, t)) >> 32;
      if (r > 255) r = 255;
      if (g > 255) g = 255;
      if (b > 255) b = 255;
    end
    p.c_real     = cr[31:0];
    p.c_imag     = ci[31:0];
    p.iter_count = n[15:0];
    p.red        = r[7:0];
    p.green      = g[7:0];
    p.blue       = b[7:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && done_o) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result, iter_count", iter_count_o, -1);
      end else begin
        want = pending_pixels.pop_front();
        if (c_real_o !== want.c_real) report_mismatch("c_real", c_real_o, want.c_real);
        if (c_imag_o !== want.c_imag) report_mismatch("c_imag", c_imag_o, want.c_imag);
        if (iter_count_o !== want.iter_count)
          report_mismatch("iter_count", iter_count_o, want.iter_count);
        if (red_o !== want.red) report_mismatch("red", red_o, want.red);
        if (green_o !== want.green) report_mismatch("green", green_o, want.green);
        if (blue_o !== want.blue) report_mismatch("blue", blue_o, want.blue);
      end
    end
  end

  // write all four registers on consecutive edges; mirror each at its edge
  task automatic load_view(int re, int im, int unsigned step, int unsigned limit);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_CENTER_REAL;
    cfg_wdata_i <= re;
    @(posedge clk_i);
    view_real_q = longint'(re);
    cfg_idx_i   <= CFG_CENTER_IMAG;
    cfg_wdata_i <= im;
    @(posedge clk_i);
    view_imag_q = longint'(im);
    cfg_idx_i   <= CFG_PIXEL_STEP;
    cfg_wdata_i <= step;
    @(posedge clk_i);
    view_step_q = longint'(step & 32'h7fff_ffff);
    cfg_idx_i   <= CFG_ITER_LIMIT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    view_limit_q = longint'(limit & 32'hffff);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic drain_pixels();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // present one item, hold until taken, then maybe idle the sender
  task automatic send_pixel(int unsigned col, int unsigned row, bit has_known, pixel_t known);
    pixel_t want;
    start_i     <= 1'b1;
    pixel_col_i <= col[10:0];
    pixel_row_i <= row[10:0];
    do @(posedge clk_i); while (busy_o);
    want = predict_pixel(col, row);
    if (has_known && want != known) begin
      $display("table row disagrees with predictor for col %0d row %0d", col, row);
      error_count++;
    end
    pending_pixels.push_back(has_known ? known : want);
    if ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  pixel_row_t pixel_table[] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 1919, 1079, 0, '{0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 960, 540, 1, '{-32'sd134217728, 0, 600, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 2047, 2047, 0, '{0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 1280, 300, 0, '{0, 0, 0, 0, 0, 0}},
    // zero step and zero limit: every pixel sits on the centre, no iterations
    '{1, 0, 0, 0, 0, 2047, 0, 1, '{0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 0, 2047, 1, '{0, 0, 0, 0, 0, 0}},
    // extreme view, saturated mapping, one iteration
    '{1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1, 2047, 0, 1,
      '{32'sh7fff_ffff, 32'sh7fff_ffff, 1, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 0, 2047, 1, '{32'sh8000_0000, 32'sh8000_0000, 1, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 960, 540, 0, '{0, 0, 0, 0, 0, 0}},
    // far corner escapes on a large part; largest limit
    '{1, 32'h8000_0000, 32'h7fff_ffff, 1, 65535, 960, 540, 0, '{0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
    '{1, -134217728, 0, 559240, 65535, 960, 540, 0, '{0, 0, 0, 0, 0, 0}},
    '{1, 0, 0, 4194304, 255, 0, 0, 0, '{0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 1000, 600, 0, '{0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 1919, 1079, 0, '{0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 1500, 10, 0, '{0, 0, 0, 0, 0, 0}},
    '{0, 0, 0, 0, 0, 700, 540, 0, '{0, 0, 0, 0, 0, 0}}
  };

  initial begin
    int unsigned col, row, step, limit;
    int          re, im;
    pixel_t      none;
    none = '{0, 0, 0, 0, 0, 0};
    error_count     = 0;
    sender_idle_pct = 35;
    view_real_q  = -134217728;
    view_imag_q  = 0;
    view_step_q  = 559240;
    view_limit_q = 600;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    pixel_col_i <= '0;
    pixel_row_i <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_CENTER_REAL;
    cfg_wdata_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pixel_table[k]) begin
      if (pixel_table[k].load_view) begin
        start_i <= 1'b0;
        drain_pixels();
        load_view(pixel_table[k].view_real, pixel_table[k].view_imag,
                  pixel_table[k].view_step, pixel_table[k].view_limit);
      end
      send_pixel(pixel_table[k].col, pixel_table[k].row,
                 pixel_table[k].has_known, pixel_table[k].known);
    end

    // three phases of three views: sender idles often, then more often, then never
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 46 : 0;
      for (int v = 0; v < 3; v++) begin
        re    = int'($urandom_range(0, 805306368)) - 671088640;
        im    = int'($urandom_range(0, 536870912)) - 268435456;
        step  = (32'd1 << $urandom_range(10, 21)) | $urandom_range(0, 1023);
        limit = (ph == 0 && v == 0) ? 600 : $urandom_range(1, 64);
        start_i <= 1'b0;
        drain_pixels();
        load_view(re, im, step, limit);
        for (int k = 0; k < 50; k++) begin
          // mostly on-screen pixels, some anywhere in the field range
          if ($urandom_range(9) == 0) begin
            col = $urandom_range(0, 2047);
            row = $urandom_range(0, 2047);
          end else begin
            col = $urandom_range(0, 1919);
            row = $urandom_range(0, 1079);
          end
          send_pixel(col, row, 1'b0, none);
        end
      end
    end

    start_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
